/* sv/lzd_pkg.sv */
package lzd_pkg;

    // History window; the ring arithmetic assumes a power of two
    localparam int WINDOW_SIZE = 4096;
    localparam int ADDR_W      = $clog2(WINDOW_SIZE);
    localparam int MAX_MATCH   = 63;

    // Field widths of the channels
    localparam int DIST_W = 12;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified triple, as the back end consumes it
    typedef struct packed {
        logic              is_copy;
        logic [ADDR_W-1:0] back_dist;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] literal;
    } cmd_t;

    // Queue occupancy flags
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Back end activity flags
    typedef struct packed {
        logic idle;
        logic in_copy;
    } bk_stat_t;

endpackage

/* sv/lzd_if.sv */
// Triple channel: one request carries distance, length and literal
interface lzd_in_if;
    import lzd_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic [LEN_W-1:0]  match_length;
    logic [BYTE_W-1:0] literal;

    modport source (output valid, output distance, output match_length, output literal,
                    input ready);
    modport sink   (input valid, input distance, input match_length, input literal,
                    output ready);
endinterface

// Byte channel: one request carries a decoded byte and its end-of-run mark
interface lzd_out_if;
    import lzd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

/* sv/lzd_ram.sv */
module lzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, and registered read port returning the old content on a collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/lzd_front.sv */
module lzd_front (
    lzd_in_if.sink         triples,
    input  logic           q_full,
    output logic           cmd_valid,
    output lzd_pkg::cmd_t  cmd
);
    import lzd_pkg::*;

    // Accept whenever the queue has room
    assign triples.ready = !q_full;
    assign cmd_valid     = triples.valid;

    // Classify: a zero distance or a zero length leaves the literal alone
    always_comb
    begin
        cmd.is_copy   = (triples.distance != '0) && (triples.match_length != '0);
        cmd.back_dist = ADDR_W'(triples.distance);
        cmd.literal   = triples.literal;
        // Clamp the length to the longest match
        if (triples.match_length > LEN_W'(MAX_MATCH))
        begin
            cmd.len = LEN_W'(MAX_MATCH);
        end
        else
        begin
            cmd.len = triples.match_length;
        end
    end

endmodule

/* sv/lzd_queue.sv */
module lzd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    input  lzd_pkg::cmd_t      push_data,
    input  logic               pop_ready,
    output logic               pop_valid,
    output lzd_pkg::cmd_t      pop_data,
    output lzd_pkg::q_stat_t   stat
);
    import lzd_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push;
    logic              pop;

    assign stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign pop_valid  = !stat.empty;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && !stat.full;
    assign pop        = pop_ready && pop_valid;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold the queued commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* sv/lzd_back.sv */
module lzd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  lzd_pkg::cmd_t      cmd,
    output logic               cmd_ready,
    lzd_out_if.source          decoded,
    output lzd_pkg::bk_stat_t  stat
);
    import lzd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_COPY = 2'd1;
    localparam logic [1:0] ST_LIT  = 2'd2;

    // Control state
    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic              wrapped_reg, wrapped_next;
    logic              ovalid_reg, ovalid_next;

    // Payload state
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [ADDR_W-1:0] rp_reg, rp_next;
    logic [BYTE_W-1:0] lit_reg, lit_next;
    logic              byp_reg, byp_next;
    logic [BYTE_W-1:0] byp_data_reg, byp_data_next;
    logic              vld_reg, vld_next;
    logic [BYTE_W-1:0] obyte_reg, obyte_next;
    logic              olast_reg, olast_next;

    // History port signals
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    logic              out_free;
    logic              take;
    logic              fire;
    logic              more;
    logic [BYTE_W-1:0] copy_byte;
    logic [BYTE_W-1:0] emit_byte;
    logic [ADDR_W-1:0] rp_start;
    logic [ADDR_W-1:0] rp_inc;

    assign out_free  = !ovalid_reg || decoded.ready;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign take      = cmd_valid && cmd_ready;
    assign fire      = out_free && ((state_reg == ST_COPY) || (state_reg == ST_LIT));
    assign more      = (rem_reg != LEN_W'(1));

    // Pick the copied byte: fresh bypass, stored history, or a never-written zero
    assign copy_byte = byp_reg ? byp_data_reg : (vld_reg ? ram_rdata : '0);
    assign emit_byte = (state_reg == ST_LIT) ? lit_reg : copy_byte;

    assign rp_start  = wp_reg - cmd.back_dist;
    assign rp_inc    = rp_reg + 1'b1;

    // Read the source of the next copied byte ahead, through the registered read port
    assign ram_re    = (take && cmd.is_copy) || (fire && (state_reg == ST_COPY) && more);
    assign ram_raddr = take ? rp_start : rp_inc;

    lzd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_SIZE)
    ) u_hist (
        .clk   (clk),
        .we    (fire),
        .waddr (wp_reg),
        .wdata (emit_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequence the copy and the literal
    always_comb
    begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        wrapped_next  = wrapped_reg;
        rem_next      = rem_reg;
        rp_next       = rp_reg;
        lit_next      = lit_reg;
        byp_next      = byp_reg;
        byp_data_next = byp_data_reg;
        vld_next      = vld_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    lit_next = cmd.literal;
                    rem_next = cmd.len;
                    rp_next  = rp_start;
                    byp_next = 1'b0;
                    vld_next = wrapped_reg || (rp_start < wp_reg);
                    state_next = cmd.is_copy ? ST_COPY : ST_LIT;
                end
            end
            ST_COPY:
            begin
                if (fire)
                begin
                    rem_next = rem_reg - 1'b1;
                    rp_next  = rp_inc;
                    // Forward the byte written now if the next source is that slot
                    byp_next      = (rp_inc == wp_reg);
                    byp_data_next = emit_byte;
                    vld_next      = wrapped_reg || (rp_inc < wp_reg);
                    if (!more)
                    begin
                        state_next = ST_LIT;
                    end
                end
            end
            ST_LIT:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Advance the write position on every emitted byte
        if (fire)
        begin
            wp_next = wp_reg + 1'b1;
            if (wp_reg == ADDR_W'(WINDOW_SIZE - 1))
            begin
                wrapped_next = 1'b1;
            end
        end
    end

    // Output register: load on emit, drop when taken
    always_comb
    begin
        ovalid_next = ovalid_reg;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        if (fire)
        begin
            ovalid_next = 1'b1;
            obyte_next  = emit_byte;
            olast_next  = (state_reg == ST_LIT);
        end
        else if (decoded.ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            wrapped_reg <= wrapped_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        rp_reg       <= rp_next;
        lit_reg      <= lit_next;
        byp_reg      <= byp_next;
        byp_data_reg <= byp_data_next;
        vld_reg      <= vld_next;
        obyte_reg    <= obyte_next;
        olast_reg    <= olast_next;
    end

    assign decoded.valid     = ovalid_reg;
    assign decoded.data_byte = obyte_reg;
    assign decoded.last      = olast_reg;

    assign stat.idle    = (state_reg == ST_IDLE);
    assign stat.in_copy = (state_reg == ST_COPY);

endmodule

/* sv/lz77_triple_decoder.sv */
// Channel   | Modport | Payload                                | Request moves
// ----------+---------+----------------------------------------+------------------------
// triples   | sink    | distance[11:0] match_length[5:0] lit[7:0] | one LZ77 triple
// decoded   | source  | data_byte[7:0] last                    | one decoded byte
//
// In the back end a copy triple is dispatched from idle, then emits one byte
// per cycle through the single history write port while the output is free,
// then the literal; a literal-only triple goes straight to the literal.
// Triples are taken into a two-deep queue while the back end works, and the
// output register lets the back end emit as the previous byte is taken.
// After reset the history reads as zeros: a write pointer and wrap flag mark
// slots never written, so no clearing pass is run.
// A stalled output freezes the back end; the front keeps accepting until the
// queue is full.
module lz77_triple_decoder (
    input  logic       clk,
    input  logic       rst_n,
    lzd_in_if.sink     triples,
    lzd_out_if.source  decoded
);
    import lzd_pkg::*;

    cmd_t     f_cmd;
    logic     f_valid;
    cmd_t     q_cmd;
    logic     q_valid;
    logic     b_ready;
    q_stat_t  q_stat;
    bk_stat_t b_stat;

    lzd_front u_front (
        .triples   (triples),
        .q_full    (q_stat.full),
        .cmd_valid (f_valid),
        .cmd       (f_cmd)
    );

    lzd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_data  (f_cmd),
        .pop_ready  (b_ready),
        .pop_valid  (q_valid),
        .pop_data   (q_cmd),
        .stat       (q_stat)
    );

    lzd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_ready (b_ready),
        .decoded   (decoded),
        .stat      (b_stat)
    );

    // A dispatched command leaves the back end busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && b_ready |=> !b_stat.idle)
        else $error("back end idle after dispatch");

    // A copy phase only begins straight after a dispatch
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(b_stat.in_copy) |-> $past(q_valid && b_ready))
        else $error("copy started without a dispatched command");

    // An accepted triple never meets a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        triples.valid && triples.ready |-> !q_stat.full)
        else $error("triple accepted into a full queue");

endmodule
